@@ src/lpwpp_pkg.sv @@
// ----------------------------------------------------------------------------
// lpwpp_pkg
// Shared types and codes for the length-prefixed word packet parser.
// ----------------------------------------------------------------------------
package lpwpp_pkg;

    localparam int unsigned QUEUE_DEPTH_DEF = 4;
    localparam logic [30:0] MAX_SIZE_RESET  = 31'd16384;

    // event kinds
    localparam logic [1:0] EV_HEADER   = 2'd0;
    localparam logic [1:0] EV_DATA     = 2'd1;
    localparam logic [1:0] EV_WORD_END = 2'd2;
    localparam logic [1:0] EV_ERROR    = 2'd3;

    // error codes
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_OVERSIZE = 2'd1;
    localparam logic [1:0] ERR_TRUNC    = 2'd2;
    localparam logic [1:0] ERR_BAD_TERM = 2'd3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_buffer;
    } t_in;

    typedef struct packed {
        logic [1:0]         event_kind;
        logic               from_client;
        logic               is_response;
        logic [29:0]        sequence_number;
        logic signed [31:0] declared_size;
        logic [30:0]        word_count;
        logic [30:0]        word_position;
        logic [7:0]         word_data;
        logic [1:0]         error_code;
        logic               packet_done;
    } t_out;

endpackage

@@ src/lpwpp_front.sv @@
// ----------------------------------------------------------------------------
// lpwpp_front
// Byte-level parser: assembles header and length words, tracks words and
// bytes, and pushes at most one result per accepted byte into the queue.
// ----------------------------------------------------------------------------
module lpwpp_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    input  lpwpp_pkg::t_in     i_in_data,
    output logic               o_in_stall,
    input  logic               i_cfg_valid,
    input  logic [30:0]        i_cfg_data,
    input  logic               i_q_full,
    output logic               o_push,
    output lpwpp_pkg::t_out    o_push_data
);
    import lpwpp_pkg::*;

    typedef enum logic [2:0] {
        PH_SEQ, PH_SIZE, PH_COUNT, PH_WLEN, PH_WDATA, PH_WTERM, PH_SKIP
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [1:0]  r_cnt, n_cnt;
    logic [31:0] r_asm, n_asm;
    logic [31:0] r_seq, n_seq;
    logic [31:0] r_size, n_size;
    logic [30:0] r_words, n_words;
    logic [30:0] r_wbytes, n_wbytes;
    logic [30:0] r_cur, n_cur;
    logic [30:0] r_max;

    logic        accept;
    logic [7:0]  b;
    logic        eob;
    logic [31:0] w;
    logic [30:0] cnt_val;
    logic [30:0] words_dec;
    logic        do_err;
    logic        do_finish;
    logic [1:0]  err_code;
    t_out        res;
    logic        res_valid;

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign b          = i_in_data.data_byte;
    assign eob        = i_in_data.end_of_buffer;
    assign w          = {b, r_asm[23:0]};
    assign cnt_val    = w[31] ? '0 : w[30:0];
    assign words_dec  = (r_words != '0) ? r_words - 31'd1 : r_words;

    always_comb begin
        n_phase   = r_phase;
        n_cnt     = r_cnt;
        n_asm     = r_asm;
        n_seq     = r_seq;
        n_size    = r_size;
        n_words   = r_words;
        n_wbytes  = r_wbytes;
        n_cur     = r_cur;
        do_err    = 1'b0;
        do_finish = 1'b0;
        err_code  = ERR_NONE;
        res       = '0;
        res_valid = 1'b0;

        if (accept) begin
            case (r_phase)
                PH_SEQ, PH_SIZE, PH_COUNT, PH_WLEN: begin
                    if (r_cnt != 2'd3) begin
                        n_asm[{r_cnt, 3'b000} +: 8] = b;
                        n_cnt = r_cnt + 2'd1;
                        if (eob) begin
                            do_err   = 1'b1;
                            err_code = ERR_TRUNC;
                        end
                    end else begin
                        n_cnt = '0;
                        n_asm = '0;
                        case (r_phase)
                            PH_SEQ: begin
                                n_seq = w;
                                if (eob) begin
                                    do_err   = 1'b1;
                                    err_code = ERR_TRUNC;
                                end else begin
                                    n_phase = PH_SIZE;
                                end
                            end
                            PH_SIZE: begin
                                n_size = w;
                                // negative sizes are never oversize
                                if (!w[31] && (w[30:0] > r_max)) begin
                                    do_err   = 1'b1;
                                    err_code = ERR_OVERSIZE;
                                end else if (eob) begin
                                    do_err   = 1'b1;
                                    err_code = ERR_TRUNC;
                                end else begin
                                    n_phase = PH_COUNT;
                                end
                            end
                            PH_COUNT: begin
                                if ((cnt_val != '0) && eob) begin
                                    do_err   = 1'b1;
                                    err_code = ERR_TRUNC;
                                end else begin
                                    res_valid           = 1'b1;
                                    res.event_kind      = EV_HEADER;
                                    res.from_client     = r_seq[31];
                                    res.is_response     = r_seq[30];
                                    res.sequence_number = r_seq[29:0];
                                    res.declared_size   = r_size;
                                    res.word_count      = cnt_val;
                                    n_words             = cnt_val;
                                    n_cur               = '0;
                                    if (cnt_val == '0) begin
                                        res.packet_done = 1'b1;
                                        do_finish       = 1'b1;
                                    end else begin
                                        n_phase = PH_WLEN;
                                    end
                                end
                            end
                            default: begin
                                // word length; a negative length can never fit
                                if (w[31] || eob) begin
                                    do_err   = 1'b1;
                                    err_code = ERR_TRUNC;
                                end else begin
                                    n_wbytes = w[30:0];
                                    n_phase  = (w[30:0] == '0) ? PH_WTERM : PH_WDATA;
                                end
                            end
                        endcase
                    end
                end
                PH_WDATA: begin
                    if (eob) begin
                        do_err   = 1'b1;
                        err_code = ERR_TRUNC;
                    end else begin
                        res_valid         = 1'b1;
                        res.event_kind    = EV_DATA;
                        res.word_position = r_cur;
                        res.word_data     = b;
                        n_wbytes          = r_wbytes - 31'd1;
                        if (r_wbytes == 31'd1) begin
                            n_phase = PH_WTERM;
                        end
                    end
                end
                PH_WTERM: begin
                    if (b != 8'd0) begin
                        do_err   = 1'b1;
                        err_code = ERR_BAD_TERM;
                    end else if ((r_words > 31'd1) && eob) begin
                        do_err   = 1'b1;
                        err_code = ERR_TRUNC;
                    end else begin
                        res_valid         = 1'b1;
                        res.event_kind    = EV_WORD_END;
                        res.word_position = r_cur;
                        n_words           = words_dec;
                        n_cur             = r_cur + 31'd1;
                        if (words_dec == '0) begin
                            res.packet_done = 1'b1;
                            do_finish       = 1'b1;
                        end else begin
                            n_phase = PH_WLEN;
                        end
                    end
                end
                PH_SKIP: begin
                    if (eob) begin
                        n_phase = PH_SEQ;
                    end
                end
                default: begin
                    n_phase = PH_SEQ;
                end
            endcase

            if (do_err) begin
                res_valid       = 1'b1;
                res             = '0;
                res.event_kind  = EV_ERROR;
                res.error_code  = err_code;
                res.packet_done = 1'b1;
                do_finish       = 1'b1;
            end
            // drop trailing bytes until the buffer ends
            if (do_finish) begin
                n_phase = eob ? PH_SEQ : PH_SKIP;
                n_cnt   = '0;
                n_asm   = '0;
            end
        end
    end

    assign o_push      = res_valid;
    assign o_push_data = res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_SEQ;
            r_cnt    <= '0;
            r_asm    <= '0;
            r_seq    <= '0;
            r_size   <= '0;
            r_words  <= '0;
            r_wbytes <= '0;
            r_cur    <= '0;
            r_max    <= MAX_SIZE_RESET;
        end else begin
            r_phase  <= n_phase;
            r_cnt    <= n_cnt;
            r_asm    <= n_asm;
            r_seq    <= n_seq;
            r_size   <= n_size;
            r_words  <= n_words;
            r_wbytes <= n_wbytes;
            r_cur    <= n_cur;
            if (i_cfg_valid) begin
                r_max <= i_cfg_data;
            end
        end
    end

endmodule

@@ src/lpwpp_queue.sv @@
// ----------------------------------------------------------------------------
// lpwpp_queue
// Short result queue between the parser and the output stage.
// ----------------------------------------------------------------------------
module lpwpp_queue #(
    parameter int unsigned DEPTH = lpwpp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  lpwpp_pkg::t_out i_push_data,
    input  logic            i_pop,
    output lpwpp_pkg::t_out o_head,
    output logic            o_empty,
    output logic            o_full
);
    import lpwpp_pkg::*;

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_out          r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == FULL_CNT);
    assign o_head  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == LAST) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == LAST) ? '0 : r_rd + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule

@@ src/lpwpp_back.sv @@
// ----------------------------------------------------------------------------
// lpwpp_back
// Output stage: pulls results from the queue into the output register and
// holds them until the downstream side takes the transfer.
// ----------------------------------------------------------------------------
module lpwpp_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  lpwpp_pkg::t_out i_head,
    input  logic            i_empty,
    output logic            o_pop,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output lpwpp_pkg::t_out o_out_data
);
    import lpwpp_pkg::*;

    logic r_valid;
    t_out r_data;

    // refill when the register is empty or its transfer completes now
    assign o_pop = !i_empty && (!r_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= i_head;
        end
    end

    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

endmodule

@@ src/length_prefixed_word_packet_parser_top.sv @@
// ----------------------------------------------------------------------------
// length_prefixed_word_packet_parser_top
// Deframes a byte stream of length-prefixed word packets into header, word
// byte, word end and error events.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+---------------------------
//   in      | input     | i_in_valid/o_in_stall   | t_in  (byte, end flag)
//   out     | output    | o_out_valid/i_out_stall | t_out (one event)
//   cfg     | input     | i_cfg_valid/o_cfg_ready | max packet size, 31 bits
//
// One byte is taken per cycle while the result queue has room.
// A result passes from the parser into the queue and from the queue into
// the output register.
// Input stalls only when the QUEUE_DEPTH-entry result queue is full.
// Reset is synchronous; it restores the parser and the size limit (16384).
// ----------------------------------------------------------------------------
module length_prefixed_word_packet_parser_top #(
    parameter int unsigned QUEUE_DEPTH = lpwpp_pkg::QUEUE_DEPTH_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_stall,
    input  lpwpp_pkg::t_in  i_in_data,
    output logic            o_out_valid,
    input  logic            i_out_stall,
    output lpwpp_pkg::t_out o_out_data,
    input  logic            i_cfg_valid,
    output logic            o_cfg_ready,
    input  logic [30:0]     i_cfg_data
);
    import lpwpp_pkg::*;

    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    t_out push_data;
    t_out head;

    assign o_cfg_ready = 1'b1;

    lpwpp_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_push_data (push_data)
    );

    lpwpp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_push_data (push_data),
        .i_pop       (pop),
        .o_head      (head),
        .o_empty     (q_empty),
        .o_full      (q_full)
    );

    lpwpp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (head),
        .i_empty     (q_empty),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

endmodule

@@ src/lpwpp_checker.sv @@
// ----------------------------------------------------------------------------
// lpwpp_checker
// Port-level checks on the parser's output events, bound to the top level.
// ----------------------------------------------------------------------------
module lpwpp_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            o_in_stall,
    input lpwpp_pkg::t_in  i_in_data,
    input logic            o_out_valid,
    input logic            i_out_stall,
    input lpwpp_pkg::t_out o_out_data
);
    import lpwpp_pkg::*;

    // a stalled transfer keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("output payload changed under stall");

    // reset empties the queue and the output register
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("output or stall active after reset");

    a_err_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.event_kind == EV_ERROR)
        |-> o_out_data.packet_done && (o_out_data.error_code != ERR_NONE))
        else $error("error event without done or code");

    a_non_header_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.event_kind != EV_HEADER)
        |-> (o_out_data.sequence_number == '0) && (o_out_data.declared_size == '0)
            && (o_out_data.word_count == '0))
        else $error("header fields set outside a header event");

    a_data_not_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.event_kind == EV_DATA)
        |-> !o_out_data.packet_done && (o_out_data.error_code == ERR_NONE))
        else $error("data byte event marked done or errored");

endmodule

bind length_prefixed_word_packet_parser_top lpwpp_checker u_lpwpp_checker (.*);

@@ dv/length_prefixed_word_packet_parser_top_test.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// length_prefixed_word_packet_parser_top_test
// Feeds byte buffers of length-prefixed word packets into the parser: short
// directed frames, size limit settings, then random traffic of well-formed,
// cut, corrupted and noise frames under three idling mixes. Every event out
// of the block is checked field by field against a byte-level deframer
// kept in the bench.
// ----------------------------------------------------------------------------
module length_prefixed_word_packet_parser_top_test;
    import lpwpp_pkg::*;

    localparam int SETTLE_CYCLES = 8;
    localparam int CYCLE_LIMIT   = 400000;

    typedef enum logic [2:0] {
        ST_SEQ_WORD,
        ST_SIZE_WORD,
        ST_COUNT_WORD,
        ST_LEN_WORD,
        ST_WORD_DATA,
        ST_TERMINATOR,
        ST_DISCARD
    } t_parse_phase;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    t_in         i_in_data;
    logic        o_out_valid;
    logic        i_out_stall;
    t_out        o_out_data;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [30:0] i_cfg_data;

    // deframer state
    t_parse_phase phase;
    logic [1:0]   field_cnt;
    logic [31:0]  field_acc;
    logic [31:0]  seq_word;
    logic [31:0]  size_word;
    logic [30:0]  words_left;
    logic [31:0]  bytes_left;
    logic [30:0]  word_idx;
    logic [30:0]  size_limit;

    t_out        pending_events[$];
    logic [7:0]  frame_bytes[$];
    int          term_pos[$];
    int          send_gap_pct;
    int          recv_stall_pct;
    int          bytes_sent;
    int          events_seen;
    int          mismatch_count;
    int          cycle_count;

    length_prefixed_word_packet_parser_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Deframer
    // ------------------------------------------------------------------
    task automatic close_packet(input logic eob);
        phase     = eob ? ST_SEQ_WORD : ST_DISCARD;
        field_cnt = '0;
        field_acc = '0;
    endtask

    task automatic deframe_byte(input t_in item);
        t_out        ev;
        logic [31:0] w;
        logic [30:0] n;
        logic [1:0]  err;
        logic        emit;
        logic        eob;

        ev   = '0;
        err  = ERR_NONE;
        emit = 1'b0;
        eob  = item.end_of_buffer;
        case (phase)
            ST_SEQ_WORD, ST_SIZE_WORD, ST_COUNT_WORD, ST_LEN_WORD: begin
                field_acc = field_acc | (32'(item.data_byte) << (8 * field_cnt));
                if (field_cnt != 2'd3) begin
                    field_cnt++;
                    if (eob) err = ERR_TRUNC;
                end else begin
                    w         = field_acc;
                    field_cnt = '0;
                    field_acc = '0;
                    case (phase)
                        ST_SEQ_WORD: begin
                            seq_word = w;
                            if (eob) err = ERR_TRUNC;
                            else phase = ST_SIZE_WORD;
                        end
                        ST_SIZE_WORD: begin
                            size_word = w;
                            // size check wins over the cut on the same byte
                            if (!w[31] && w[30:0] > size_limit) err = ERR_OVERSIZE;
                            else if (eob) err = ERR_TRUNC;
                            else phase = ST_COUNT_WORD;
                        end
                        ST_COUNT_WORD: begin
                            n = w[31] ? '0 : w[30:0];
                            if (n != '0 && eob) begin
                                err = ERR_TRUNC;
                            end else begin
                                emit               = 1'b1;
                                ev.event_kind      = EV_HEADER;
                                ev.from_client     = seq_word[31];
                                ev.is_response     = seq_word[30];
                                ev.sequence_number = seq_word[29:0];
                                ev.declared_size   = size_word;
                                ev.word_count      = n;
                                words_left         = n;
                                word_idx           = '0;
                                if (n == '0) begin
                                    ev.packet_done = 1'b1;
                                    close_packet(eob);
                                end else begin
                                    phase = ST_LEN_WORD;
                                end
                            end
                        end
                        default: begin
                            // a negative length can never fit
                            if (w[31] || eob) begin
                                err = ERR_TRUNC;
                            end else begin
                                bytes_left = w;
                                phase      = (w != '0) ? ST_WORD_DATA : ST_TERMINATOR;
                            end
                        end
                    endcase
                end
            end
            ST_WORD_DATA: begin
                if (eob) begin
                    err = ERR_TRUNC;
                end else begin
                    emit             = 1'b1;
                    ev.event_kind    = EV_DATA;
                    ev.word_position = word_idx;
                    ev.word_data     = item.data_byte;
                    bytes_left--;
                    if (bytes_left == '0) phase = ST_TERMINATOR;
                end
            end
            ST_TERMINATOR: begin
                if (item.data_byte != 8'h00) begin
                    err = ERR_BAD_TERM;
                end else if (words_left > 31'd1 && eob) begin
                    err = ERR_TRUNC;
                end else begin
                    emit             = 1'b1;
                    ev.event_kind    = EV_WORD_END;
                    ev.word_position = word_idx;
                    if (words_left != '0) words_left--;
                    word_idx++;
                    if (words_left == '0) begin
                        ev.packet_done = 1'b1;
                        close_packet(eob);
                    end else begin
                        phase = ST_LEN_WORD;
                    end
                end
            end
            default: begin
                if (eob) close_packet(eob);
            end
        endcase
        if (err != ERR_NONE) begin
            emit           = 1'b1;
            ev.event_kind  = EV_ERROR;
            ev.error_code  = err;
            ev.packet_done = 1'b1;
            close_packet(eob);
        end
        if (emit) pending_events.push_back(ev);
    endtask

    // ------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------
    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("event %0d: %s expected %0h, got %0h", events_seen, name, want, got);
        end
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_events.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("event %0d: unexpected transfer %h", events_seen, o_out_data);
            end else begin
                want = pending_events.pop_front();
                compare_field("event_kind", want.event_kind, o_out_data.event_kind);
                compare_field("from_client", want.from_client, o_out_data.from_client);
                compare_field("is_response", want.is_response, o_out_data.is_response);
                compare_field("sequence_number", want.sequence_number,
                              o_out_data.sequence_number);
                compare_field("declared_size", want.declared_size, o_out_data.declared_size);
                compare_field("word_count", want.word_count, o_out_data.word_count);
                compare_field("word_position", want.word_position, o_out_data.word_position);
                compare_field("word_data", want.word_data, o_out_data.word_data);
                compare_field("error_code", want.error_code, o_out_data.error_code);
                compare_field("packet_done", want.packet_done, o_out_data.packet_done);
            end
            events_seen++;
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input logic last);
        t_in item;
        item = '{data_byte: b, end_of_buffer: last};
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_gap_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= item;
        do @(posedge i_clk); while (o_in_stall);
        deframe_byte(item);
        bytes_sent++;
    endtask

    // hold the input quiet until every event has come out, then let it settle
    task automatic wait_drained();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_events.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_size_limit(input logic [30:0] limit);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= limit;
        do @(posedge i_clk); while (!o_cfg_ready);
        size_limit = limit;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic void append_byte(input logic [7:0] b);
        frame_bytes.push_back(b);
    endfunction

    function automatic void append_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++) frame_bytes.push_back(w[8 * i +: 8]);
    endfunction

    // send the first keep bytes of the frame; the last one ends the buffer
    task automatic send_frame(input int keep);
        for (int i = 0; i < keep; i++) send_byte(frame_bytes[i], i == keep - 1);
        frame_bytes.delete();
        term_pos.delete();
    endtask

    task automatic build_packet();
        logic [31:0] size;
        logic [31:0] count;
        logic [31:0] len;
        int          nwords;
        int          pick;

        frame_bytes.delete();
        term_pos.delete();
        case ($urandom_range(0, 7))
            0:       size = 32'(size_limit);
            1:       size = 32'(size_limit) + 32'd1;
            2:       size = {1'b1, 31'($urandom())};
            3:       size = $urandom();
            default: size = $urandom_range(0, size_limit);
        endcase
        pick = $urandom_range(0, 19);
        if (pick < 2)      count = {1'b1, 31'($urandom())};
        else if (pick < 4) count = {1'b0, 31'($urandom())} | 32'd16;
        else               count = $urandom_range(0, 4);
        if (count[31])      nwords = 0;
        else if (count > 4) nwords = $urandom_range(0, 3);
        else                nwords = int'(count);
        append_word($urandom());
        append_word(size);
        append_word(count);
        for (int i = 0; i < nwords; i++) begin
            if ($urandom_range(0, 29) == 0) len = {1'b1, 31'($urandom())};
            else len = $urandom_range(0, 6);
            append_word(len);
            if (!len[31]) repeat (len) append_byte(8'($urandom()));
            term_pos.push_back(frame_bytes.size());
            append_byte(8'h00);
        end
    endtask

    task automatic send_random_frame();
        int pick;
        int keep;
        int idx;

        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            frame_bytes.delete();
            repeat ($urandom_range(1, 24)) append_byte(8'($urandom()));
            send_frame(frame_bytes.size());
            return;
        end
        build_packet();
        keep = frame_bytes.size();
        if (pick < 55) begin
            // trailing bytes after a complete packet
            repeat ($urandom_range(0, 3)) append_byte(8'($urandom()));
            keep = frame_bytes.size();
        end else if (pick < 70) begin
            keep = $urandom_range(1, frame_bytes.size());
        end else if (pick < 80) begin
            if (term_pos.size() != 0) begin
                idx = term_pos[$urandom_range(0, term_pos.size() - 1)];
                frame_bytes[idx] = 8'($urandom_range(1, 255));
                if ($urandom_range(0, 1) != 0) keep = idx + 1;
            end
        end else if (pick < 88) begin
            keep = 12;
        end else if (term_pos.size() != 0) begin
            keep = term_pos[0] + 1;
        end
        send_frame(keep);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed_frames();
        // cut inside the sequence word
        send_byte(8'hFF, 1'b1);
        // oversize reported on the same byte that ends the buffer
        append_word(32'hFFFF_FFFF);
        append_word(32'h7FFF_FFFF);
        send_frame(8);
        // negative size and negative count: header with no words
        append_word(32'h0000_0000);
        append_word(32'h8000_0000);
        append_word(32'hFFFF_FFFF);
        send_frame(12);
        send_byte(8'h00, 1'b1);
    endtask

    task automatic test_size_limit();
        write_size_limit('0);
        append_word(32'h4000_0001);
        append_word(32'd0);
        append_word(32'd0);
        send_frame(frame_bytes.size());
        append_word(32'h8000_0002);
        append_word(32'd1);
        append_word(32'd0);
        append_byte(8'h5A);
        send_frame(frame_bytes.size());
        write_size_limit(31'h7FFF_FFFF);
        append_word(32'h3FFF_FFFF);
        append_word(32'h7FFF_FFFF);
        append_word(32'd1);
        append_word(32'd2);
        append_byte(8'h00);
        append_byte(8'hFF);
        append_byte(8'h00);
        send_frame(frame_bytes.size());
    endtask

    task automatic test_random_traffic(input int gap_pct, input int stall_pct,
                                       input logic [30:0] limit, input int n_bytes);
        int stop_at;
        int frames;

        send_gap_pct   = gap_pct;
        recv_stall_pct = stall_pct;
        write_size_limit(limit);
        stop_at = bytes_sent + n_bytes;
        frames  = 0;
        while (bytes_sent < stop_at) begin
            if (frames % 25 == 12) wait_drained();
            send_random_frame();
            frames++;
        end
    endtask

    initial begin
        i_clk          = 1'b0;
        i_rst_n        = 1'b0;
        i_in_valid     = 1'b0;
        i_in_data      = '0;
        i_out_stall    = 1'b0;
        i_cfg_valid    = 1'b0;
        i_cfg_data     = '0;
        send_gap_pct   = 27;
        recv_stall_pct = 50;
        bytes_sent     = 0;
        events_seen    = 0;
        mismatch_count = 0;
        cycle_count    = 0;
        phase          = ST_SEQ_WORD;
        field_cnt      = '0;
        field_acc      = '0;
        seq_word       = '0;
        size_word      = '0;
        words_left     = '0;
        bytes_left     = '0;
        word_idx       = '0;
        size_limit     = MAX_SIZE_RESET;
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_frames();
        test_size_limit();
        test_random_traffic(27, 50, 31'd16384, 540);
        test_random_traffic(50, 27, 31'($urandom_range(1, 1000)), 530);
        test_random_traffic(0, 0, 31'($urandom_range(0, 64)), 530);

        wait_drained();
        if (mismatch_count == 0 && pending_events.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
